// ===== rtl/vat_pkg.sv =====
// ----------------------------------------------------------------------------
// vat_pkg: shared types and helpers for the vertex affine transform
// Widths, matrix storage type, lane control and the round/saturate step.
// ----------------------------------------------------------------------------
package vat_pkg;

   localparam int NUM_PAIRS  = 8;
   localparam int PAIR_IDX_W = $clog2(NUM_PAIRS);
   localparam int PAIR_W     = 64;
   localparam int COORD_W    = 32;
   localparam int NUM_LANES  = 3;
   localparam int FRAC_W     = 16;
   localparam int PROD_W     = 2 * COORD_W;
   localparam int TERM_W     = COORD_W + FRAC_W;
   localparam int PSUM_W     = PROD_W + 1;
   localparam int SUM_W      = PROD_W + 2;
   localparam int SHIFT_W    = SUM_W - FRAC_W;

   // Half an LSB of the Q16.16 result, placed below the translation term
   localparam logic [FRAC_W-1:0] ROUND_HALF = FRAC_W'(1) << (FRAC_W - 1);

   localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef logic [NUM_PAIRS-1:0][PAIR_W-1:0] mat_type;

   // Identity matrix, column-major, two Q16.16 entries per register
   localparam mat_type MAT_RESET = {
      64'h0001_0000_0000_0000,   // pair 7: entries 14, 15
      64'h0000_0000_0000_0000,   // pair 6: entries 12, 13
      64'h0000_0000_0001_0000,   // pair 5: entries 10, 11
      64'h0000_0000_0000_0000,   // pair 4: entries 8, 9
      64'h0000_0000_0000_0000,   // pair 3: entries 6, 7
      64'h0001_0000_0000_0000,   // pair 2: entries 4, 5
      64'h0000_0000_0000_0000,   // pair 1: entries 2, 3
      64'h0000_0000_0001_0000    // pair 0: entries 0, 1
   };

   typedef struct packed {
      logic signed [COORD_W-1:0] mx;
      logic signed [COORD_W-1:0] my;
      logic signed [COORD_W-1:0] mz;
      logic signed [COORD_W-1:0] mt;
   } lane_coef_type;

   typedef struct packed {
      logic load1;
      logic load2;
   } stage_ctl_type;

   // Matrix entry e (0..15): pair e/2, low half for even e
   function automatic logic signed [COORD_W-1:0] mat_entry(input mat_type m, input int e);
      logic [PAIR_IDX_W:0] ev;
      logic [PAIR_W-1:0]   pair;
      ev   = (PAIR_IDX_W + 1)'(e);
      pair = m[ev[PAIR_IDX_W:1]];
      return ev[0] ? pair[PAIR_W-1:COORD_W] : pair[COORD_W-1:0];
   endfunction

   // Sum already carries the half-LSB; shift down and clamp to 32 bits
   function automatic logic signed [COORD_W-1:0] sat_round(
      input logic signed [SUM_W-1:0] s);
      logic signed [SHIFT_W-1:0] sh;
      sh = s[SUM_W-1:FRAC_W];
      if (sh[SHIFT_W-1:COORD_W-1] == {(SHIFT_W-COORD_W+1){sh[COORD_W-1]}}) begin
         return sh[COORD_W-1:0];
      end else if (s[SUM_W-1]) begin
         return SAT_MIN;
      end else begin
         return SAT_MAX;
      end
   endfunction

endpackage

// ===== rtl/vat_if.sv =====
// ----------------------------------------------------------------------------
// vat_if: valid/ready channels of the vertex affine transform
// Request carries one vertex, response carries the transformed vertex.
// ----------------------------------------------------------------------------
interface vat_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [vat_pkg::COORD_W-1:0]    in_x;
   logic signed [vat_pkg::COORD_W-1:0]    in_y;
   logic signed [vat_pkg::COORD_W-1:0]    in_z;
   logic                                  in_last;

   modport source (output valid, in_x, in_y, in_z, in_last, input ready);
   modport sink   (input valid, in_x, in_y, in_z, in_last, output ready);
endinterface

interface vat_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [vat_pkg::COORD_W-1:0]    out_x;
   logic signed [vat_pkg::COORD_W-1:0]    out_y;
   logic signed [vat_pkg::COORD_W-1:0]    out_z;
   logic                                  out_last;

   modport source (output valid, out_x, out_y, out_z, out_last, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_last, output ready);
endinterface

// ===== rtl/vat_lane.sv =====
// ----------------------------------------------------------------------------
// vat_lane: one matrix row times the vertex
// Stage 1 multiplies, stage 2 adds pairs; the final sum is left combinational.
// ----------------------------------------------------------------------------
module vat_lane (
   input  logic                                     clock,
   input  vat_pkg::stage_ctl_type                   ctl,
   input  logic signed [vat_pkg::COORD_W-1:0]       x,
   input  logic signed [vat_pkg::COORD_W-1:0]       y,
   input  logic signed [vat_pkg::COORD_W-1:0]       z,
   input  vat_pkg::lane_coef_type                   coef,
   output logic signed [vat_pkg::SUM_W-1:0]         sum
);

   logic signed [vat_pkg::PROD_W-1:0] px_ff, px_in;
   logic signed [vat_pkg::PROD_W-1:0] py_ff, py_in;
   logic signed [vat_pkg::PROD_W-1:0] pz_ff, pz_in;
   logic signed [vat_pkg::TERM_W-1:0] pt_ff, pt_in;
   logic signed [vat_pkg::PSUM_W-1:0] a_ff, a_in;
   logic signed [vat_pkg::PSUM_W-1:0] b_ff, b_in;

   always_comb begin
      px_in = vat_pkg::PROD_W'(coef.mx * x);
      py_in = vat_pkg::PROD_W'(coef.my * y);
      pz_in = vat_pkg::PROD_W'(coef.mz * z);
      // w = 1.0: translation scaled by 2^16, rounding half folded in below
      pt_in = {coef.mt, vat_pkg::ROUND_HALF};
      a_in  = vat_pkg::PSUM_W'(px_ff) + vat_pkg::PSUM_W'(py_ff);
      b_in  = vat_pkg::PSUM_W'(pz_ff) + vat_pkg::PSUM_W'(pt_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.load1) begin
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
         pt_ff <= pt_in;
      end
      if (ctl.load2) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   assign sum = vat_pkg::SUM_W'(a_ff) + vat_pkg::SUM_W'(b_ff);

endmodule

// ===== rtl/vat_merge.sv =====
// ----------------------------------------------------------------------------
// vat_merge: collects the lane sums into the response register
// Rounds and saturates each lane, then holds the vertex for the consumer.
// ----------------------------------------------------------------------------
module vat_merge (
   input  logic                                                    clock,
   input  logic                                                    load,
   input  logic signed [vat_pkg::NUM_LANES-1:0][vat_pkg::SUM_W-1:0] lane_sum,
   input  logic                                                    last,
   output logic signed [vat_pkg::COORD_W-1:0]                      out_x,
   output logic signed [vat_pkg::COORD_W-1:0]                      out_y,
   output logic signed [vat_pkg::COORD_W-1:0]                      out_z,
   output logic                                                    out_last
);

   logic signed [vat_pkg::COORD_W-1:0] x_ff, x_in;
   logic signed [vat_pkg::COORD_W-1:0] y_ff, y_in;
   logic signed [vat_pkg::COORD_W-1:0] z_ff, z_in;
   logic                               last_ff;

   always_comb begin
      x_in = vat_pkg::sat_round(lane_sum[0]);
      y_in = vat_pkg::sat_round(lane_sum[1]);
      z_in = vat_pkg::sat_round(lane_sum[2]);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         last_ff <= last;
      end
   end

   assign out_x    = x_ff;
   assign out_y    = y_ff;
   assign out_z    = z_ff;
   assign out_last = last_ff;

endmodule

// ===== rtl/vertex_affine_transform.sv =====
// ----------------------------------------------------------------------------
// vertex_affine_transform: 4x4 matrix times vertex (x, y, z, 1) in Q16.16
// Three row lanes and a merging response register behind valid/ready.
// ----------------------------------------------------------------------------
// One vertex transaction is taken per clock while rsp_ch keeps up, set by
// the three 32x32 multipliers in each lane running in parallel. Its result
// is registered in turn after the multiply, the pair add and the final add
// with round and saturate into the response register. Each stage holds
// its data only while the stage after it is full and stalled, so empty
// stages are filled even while a finished result waits on rsp_ch. The
// matrix lives in eight 64-bit registers (csr_index 0..7), column-major, two
// Q16.16 entries each, low half first; reset loads the identity. Write them
// only while no transaction is in flight. Results round to nearest (ties
// toward plus infinity) and clamp to the signed 32-bit range; the w row of
// the matrix is stored but never used.
// ----------------------------------------------------------------------------
module vertex_affine_transform (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [vat_pkg::PAIR_IDX_W-1:0]        csr_index,
   input  logic [vat_pkg::PAIR_W-1:0]            csr_wdata,
   vat_req_if.sink                               req_ch,
   vat_rsp_if.source                             rsp_ch
);

   // Matrix registers
   vat_pkg::mat_type mat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= vat_pkg::MAT_RESET;
      end else if (csr_we) begin
         mat_ff[csr_index] <= csr_wdata;
      end
   end

   // Stage occupancy and flow control; ready ripples back from the output
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;
   logic rdy1, rdy2, rdy3;
   logic last1_ff, last2_ff;
   vat_pkg::stage_ctl_type ctl;

   always_comb begin
      rdy3      = !v3_ff || rsp_ch.ready;
      rdy2      = !v2_ff || rdy3;
      rdy1      = !v1_ff || rdy2;
      ctl.load1 = req_ch.valid && rdy1;
      ctl.load2 = v1_ff && rdy2;
      v1_in     = rdy1 ? req_ch.valid : v1_ff;
      v2_in     = rdy2 ? v1_ff : v2_ff;
      v3_in     = rdy3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // The last flag rides alongside the lane data
   always_ff @(posedge clock) begin
      if (ctl.load1) begin
         last1_ff <= req_ch.in_last;
      end
      if (ctl.load2) begin
         last2_ff <= last1_ff;
      end
   end

   assign req_ch.ready = rdy1;
   assign rsp_ch.valid = v3_ff;

   // Row lanes: lane r uses column-major entries r, 4+r, 8+r and 12+r
   logic signed [vat_pkg::NUM_LANES-1:0][vat_pkg::SUM_W-1:0] lane_sum;

   for (genvar r = 0; r < vat_pkg::NUM_LANES; r++) begin : g_lane
      vat_pkg::lane_coef_type coef;

      always_comb begin
         coef.mx = vat_pkg::mat_entry(mat_ff, r);
         coef.my = vat_pkg::mat_entry(mat_ff, 4 + r);
         coef.mz = vat_pkg::mat_entry(mat_ff, 8 + r);
         coef.mt = vat_pkg::mat_entry(mat_ff, 12 + r);
      end

      vat_lane u_lane (
         .clock (clock),
         .ctl   (ctl),
         .x     (req_ch.in_x),
         .y     (req_ch.in_y),
         .z     (req_ch.in_z),
         .coef  (coef),
         .sum   (lane_sum[r])
      );
   end

   // Merge lanes into the response register
   logic signed [vat_pkg::COORD_W-1:0] out_x, out_y, out_z;
   logic                               out_last;

   vat_merge u_merge (
      .clock    (clock),
      .load     (v2_ff && rdy3),
      .lane_sum (lane_sum),
      .last     (last2_ff),
      .out_x    (out_x),
      .out_y    (out_y),
      .out_z    (out_z),
      .out_last (out_last)
   );

   assign rsp_ch.out_x    = out_x;
   assign rsp_ch.out_y    = out_y;
   assign rsp_ch.out_z    = out_z;
   assign rsp_ch.out_last = out_last;

   // Pipeline bookkeeping checks
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> v1_ff)
      else $error("accepted transaction did not enter stage 1");

   a_s1_moves_to_s2: assert property (@(posedge clock) disable iff (reset)
      v1_ff && rdy2 |=> v2_ff)
      else $error("stage 1 data lost on the way to stage 2");

   a_s2_moves_to_out: assert property (@(posedge clock) disable iff (reset)
      v2_ff && rdy3 |=> rsp_ch.valid)
      else $error("stage 2 data lost on the way to the response register");

   a_stall_holds_s2: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !rdy3 |=> v2_ff && v3_ff)
      else $error("stage 2 dropped while the output was stalled");

endmodule

// ===== tb/vertex_affine_transform_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_affine_transform_tb: self-checking bench for the vertex transform
// Streams vertex transactions through the block under a series of matrix
// settings (reset identity, saturating extremes, half-scale ties, zero,
// all-ones and random matrices), predicts each transformed vertex in wide
// fixed point and compares every response field in arrival order.
// ----------------------------------------------------------------------------
module vertex_affine_transform_tb;

   localparam int CLK_PERIOD_NS = 20;
   localparam int TIMEOUT_NS    = 10_000_000;   // far above worst case
   localparam int LATENCY_PAD   = 8;            // pipeline is three deep
   localparam int REG_COUNT     = 8;
   localparam int FRAC_BITS     = 16;
   localparam int WIDE_W        = 80;           // holds the exact Q48.32 sum

   localparam logic [31:0] Q_ONE     = 32'h0001_0000;
   localparam logic [31:0] Q_HALF    = 32'h0000_8000;
   localparam logic [31:0] Q_LSB     = 32'h0000_0001;
   localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN     = 32'h8000_0000;
   localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
   localparam logic [31:0] Q_ALL     = 32'hFFFF_FFFF;
   localparam logic [31:0] W_FILL    = 32'h5A5A_A5A5;   // junk for the unused w row

   localparam logic signed [WIDE_W-1:0] WIDE_MAX   = 80'sd2147483647;
   localparam logic signed [WIDE_W-1:0] WIDE_MIN   = -80'sd2147483648;
   localparam logic signed [WIDE_W-1:0] ROUND_BIAS = 80'sd32768;

   typedef enum logic [vat_pkg::PAIR_IDX_W-1:0] {
      MAT_PAIR_0, MAT_PAIR_1, MAT_PAIR_2, MAT_PAIR_3,
      MAT_PAIR_4, MAT_PAIR_5, MAT_PAIR_6, MAT_PAIR_7
   } mat_reg_type;

   typedef struct packed {
      logic signed [vat_pkg::COORD_W-1:0] x;
      logic signed [vat_pkg::COORD_W-1:0] y;
      logic signed [vat_pkg::COORD_W-1:0] z;
      logic                               last;
   } vertex_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [vat_pkg::PAIR_IDX_W-1:0]  csr_index;
   logic [vat_pkg::PAIR_W-1:0]      csr_wdata;

   vat_req_if req_ch ();
   vat_rsp_if rsp_ch ();

   vertex_affine_transform u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // Matrix as the block should hold it, and the next setting to load
   logic [vat_pkg::PAIR_W-1:0] mat_shadow  [REG_COUNT];
   logic [vat_pkg::PAIR_W-1:0] matrix_plan [REG_COUNT];

   vertex_type pending_vertices  [$];   // waiting for the driver
   vertex_type expected_vertices [$];   // predicted, waiting for rsp

   int  vertices_queued;
   int  vertices_taken;
   int  results_checked;
   int  field_errors;
   int  saturated_fields;
   int  matrix_settings;

   // Handshake flags captured at the rising edge, used at the falling edge
   logic req_taken;
   logic rsp_taken;

   int  src_idle;
   int  rsp_idle;
   bit  src_steady;
   bit  rsp_steady;

   always #(CLK_PERIOD_NS / 2) clock = ~clock;

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Entry e of the column-major matrix: pair e/2, low half for even e
   function automatic logic signed [31:0] coef_at(input int e);
      logic [vat_pkg::PAIR_W-1:0] pair;
      pair = mat_shadow[e / 2];
      return (e % 2) ? pair[63:32] : pair[31:0];
   endfunction

   // One output row: exact dot product with (x, y, z, 1.0), round half up,
   // clamp to signed 32 bits
   function automatic logic signed [31:0] transform_row(input int row, input vertex_type v);
      logic signed [WIDE_W-1:0] cx, cy, cz, ct, px, py, pz, acc, shifted;
      cx  = coef_at(row);
      cy  = coef_at(4 + row);
      cz  = coef_at(8 + row);
      ct  = coef_at(12 + row);
      px  = $signed(v.x);
      py  = $signed(v.y);
      pz  = $signed(v.z);
      acc = cx * px + cy * py + cz * pz + (ct <<< FRAC_BITS) + ROUND_BIAS;
      shifted = acc >>> FRAC_BITS;
      if (shifted > WIDE_MAX) begin
         return Q_MAX;
      end else if (shifted < WIDE_MIN) begin
         return Q_MIN;
      end
      return shifted[31:0];
   endfunction

   function automatic vertex_type predict_transform(input vertex_type v);
      vertex_type r;
      r.x    = transform_row(0, v);
      r.y    = transform_row(1, v);
      r.z    = transform_row(2, v);
      r.last = v.last;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Random helpers
   // -------------------------------------------------------------------------

   // Mostly zero, some short, a few long gaps; none while steady
   function automatic int pick_gap(input bit steady);
      int roll;
      roll = $urandom_range(99);
      if (steady || roll < 60) begin
         return 0;
      end else if (roll < 88) begin
         return $urandom_range(3, 1);
      end else if (roll < 97) begin
         return $urandom_range(12, 4);
      end
      return $urandom_range(60, 20);
   endfunction

   function automatic logic [31:0] pick_extreme(input logic [2:0] sel);
      case (sel)
         3'd0:    return Q_MAX;
         3'd1:    return Q_MIN;
         3'd2:    return '0;
         3'd3:    return Q_ALL;
         3'd4:    return Q_ONE;
         3'd5:    return Q_NEG_ONE;
         3'd6:    return Q_LSB;
         default: return Q_HALF;
      endcase
   endfunction

   // Full range, +-8.0, +-128.0 or a corner value
   function automatic logic [31:0] random_coord();
      logic [31:0] r;
      int          pick;
      r    = $urandom();
      pick = $urandom_range(99);
      if (pick < 50) begin
         return r;
      end else if (pick < 75) begin
         return {{12{r[19]}}, r[19:0]};
      end else if (pick < 90) begin
         return {{8{r[23]}}, r[23:0]};
      end
      return pick_extreme(r[26:24]);
   endfunction

   // Matrix entries: realistic +-4.0 scales, full range, zero or corners
   function automatic logic [31:0] random_coef();
      logic [31:0] r;
      int          pick;
      r    = $urandom();
      pick = $urandom_range(99);
      if (pick < 45) begin
         return {{13{r[18]}}, r[18:0]};
      end else if (pick < 80) begin
         return r;
      end else if (pick < 88) begin
         return '0;
      end
      return pick_extreme(r[26:24]);
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus and configuration tasks (called from the sequencing block)
   // -------------------------------------------------------------------------

   task automatic set_entry(input int e, input logic [31:0] value);
      matrix_plan[e / 2][32 * (e % 2) +: 32] = value;
   endtask

   task automatic fill_plan(input logic [31:0] value);
      for (int k = 0; k < REG_COUNT; k++) begin
         matrix_plan[k] = {value, value};
      end
   endtask

   // Writes all eight pair registers back to back; block must be idle
   task automatic load_matrix();
      for (int k = 0; k < REG_COUNT; k++) begin
         @(negedge clock);
         csr_we        <= 1'b1;
         csr_index     <= mat_reg_type'(k);
         csr_wdata     <= matrix_plan[k];
         mat_shadow[k]  = matrix_plan[k];
      end
      @(negedge clock);
      csr_we <= 1'b0;
      matrix_settings++;
      @(posedge clock);
   endtask

   task automatic push_vertex(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic last);
      vertex_type v;
      v.x    = x;
      v.y    = y;
      v.z    = z;
      v.last = last;
      pending_vertices.push_back(v);
      vertices_queued++;
   endtask

   task automatic push_random(input int count);
      for (int n = 0; n < count; n++) begin
         push_vertex(random_coord(), random_coord(), random_coord(),
                     ($urandom_range(5) == 0));
      end
   endtask

   // Every transaction accepted and every result back, then let the
   // pipeline settle before touching the matrix again
   task automatic wait_for_drain();
      do begin
         @(negedge clock);
      end while (vertices_taken != vertices_queued || expected_vertices.size() != 0);
      repeat (LATENCY_PAD) @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%h, got 0x%h", name, want, got);
         field_errors++;
      end
      if (name != "out_last" && (want == Q_MAX || want == Q_MIN)) begin
         saturated_fields++;
      end
   endtask

   // -------------------------------------------------------------------------
   // Driver side: request valid and response ready, both moved on the
   // falling edge so the block sees stable inputs at the rising edge
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : drive_side
      vertex_type item;
      if (!reset) begin
         // Source: only move on after the current transaction went through
         if (!req_ch.valid || req_taken) begin
            if (src_idle > 0) begin
               src_idle--;
               req_ch.valid <= 1'b0;
            end else if (pending_vertices.size() != 0) begin
               item = pending_vertices.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.in_x    <= item.x;
               req_ch.in_y    <= item.y;
               req_ch.in_z    <= item.z;
               req_ch.in_last <= item.last;
               src_idle = pick_gap(src_steady);
               if ($urandom_range(47) == 0) begin
                  src_steady = !src_steady;
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end

         // Sink: a stall may follow each accepted response
         if (rsp_taken) begin
            rsp_idle = pick_gap(rsp_steady);
            if ($urandom_range(47) == 0) begin
               rsp_steady = !rsp_steady;
            end
         end
         if (rsp_idle > 0) begin
            rsp_idle--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: predicts on each accepted request, checks each accepted
   // response against the oldest prediction
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : monitor_side
      vertex_type sent;
      vertex_type got;
      vertex_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         rsp_taken <= rsp_ch.valid && rsp_ch.ready;

         if (req_ch.valid && req_ch.ready) begin
            sent.x    = req_ch.in_x;
            sent.y    = req_ch.in_y;
            sent.z    = req_ch.in_z;
            sent.last = req_ch.in_last;
            expected_vertices.push_back(predict_transform(sent));
            vertices_taken++;
         end

         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_vertices.size() == 0) begin
               $error("rsp transaction with no pending expectation");
               field_errors++;
            end else begin
               want = expected_vertices.pop_front();
               got.x    = rsp_ch.out_x;
               got.y    = rsp_ch.out_y;
               got.z    = rsp_ch.out_z;
               got.last = rsp_ch.out_last;
               check_field("out_x", want.x, got.x);
               check_field("out_y", want.y, got.y);
               check_field("out_z", want.z, got.z);
               check_field("out_last", {31'b0, want.last}, {31'b0, got.last});
               results_checked++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sequencing: reset, then one batch per matrix setting
   // -------------------------------------------------------------------------
   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = MAT_PAIR_0;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.in_x    = '0;
      req_ch.in_y    = '0;
      req_ch.in_z    = '0;
      req_ch.in_last = 1'b0;
      rsp_ch.ready   = 1'b0;
      req_taken      = 1'b0;
      rsp_taken      = 1'b0;
      src_idle       = 0;
      rsp_idle       = 0;
      src_steady     = 1'b0;
      rsp_steady     = 1'b0;
      vertices_queued  = 0;
      vertices_taken   = 0;
      results_checked  = 0;
      field_errors     = 0;
      saturated_fields = 0;
      matrix_settings  = 0;

      // Reset contents: identity, w row included
      fill_plan('0);
      set_entry(0, Q_ONE);
      set_entry(5, Q_ONE);
      set_entry(10, Q_ONE);
      set_entry(15, Q_ONE);
      mat_shadow = matrix_plan;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Identity out of reset: vertices must come back unchanged
      push_vertex('0, '0, '0, 1'b0);
      push_vertex(Q_MAX, Q_MAX, Q_MAX, 1'b1);
      push_vertex(Q_MIN, Q_MIN, Q_MIN, 1'b0);
      push_vertex(Q_ALL, Q_LSB, Q_ONE, 1'b1);
      push_vertex(32'h1234_5678, 32'h89AB_CDEF, 32'h7FFF_0001, 1'b0);
      push_vertex(32'h5555_5555, 32'hAAAA_AAAA, Q_NEG_ONE, 1'b1);
      push_random(40);
      wait_for_drain();

      // Every entry at the positive limit: both saturation directions and
      // the largest translation that still fits exactly
      fill_plan(Q_MAX);
      load_matrix();
      push_vertex(Q_MAX, Q_MAX, Q_MAX, 1'b1);
      push_vertex(Q_MIN, Q_MIN, Q_MIN, 1'b0);
      push_vertex('0, '0, '0, 1'b1);
      push_vertex(Q_LSB, Q_ALL, '0, 1'b0);
      push_random(30);
      wait_for_drain();

      // Every entry at the negative limit
      fill_plan(Q_MIN);
      load_matrix();
      push_vertex(Q_MIN, Q_MIN, Q_MIN, 1'b0);
      push_vertex(Q_MAX, Q_MAX, Q_MAX, 1'b1);
      push_vertex('0, '0, '0, 1'b0);
      push_random(30);
      wait_for_drain();

      // Half-scale diagonal: odd inputs land exactly on a rounding tie,
      // which must go toward plus infinity; w row holds junk and is ignored
      fill_plan('0);
      set_entry(0, Q_HALF);
      set_entry(5, Q_HALF);
      set_entry(10, Q_HALF);
      set_entry(3, W_FILL);
      set_entry(7, W_FILL);
      set_entry(11, W_FILL);
      set_entry(15, W_FILL);
      load_matrix();
      push_vertex(Q_LSB, Q_ALL, 32'h0000_0003, 1'b0);
      push_vertex(32'hFFFF_FFFD, Q_MAX, Q_MIN, 1'b1);
      push_vertex(Q_LSB, Q_LSB, Q_LSB, 1'b0);
      push_random(30);
      wait_for_drain();

      // Zero matrix: everything collapses to zero
      fill_plan('0);
      load_matrix();
      push_random(30);
      wait_for_drain();

      // All register bits set: every entry is minus one LSB
      fill_plan(Q_ALL);
      load_matrix();
      push_random(30);
      wait_for_drain();

      // Random matrices carry the bulk of the traffic
      repeat (6) begin
         for (int k = 0; k < REG_COUNT; k++) begin
            matrix_plan[k] = {random_coef(), random_coef()};
         end
         load_matrix();
         push_random(80);
         wait_for_drain();
      end

      $display("covered %0d matrix settings, %0d vertex transactions, %0d results checked",
               matrix_settings + 1, vertices_taken, results_checked);
      $display("%0d result fields saturated, %0d field mismatches",
               saturated_fields, field_errors);
      if (field_errors == 0 && expected_vertices.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
